// ----- rtl/dwc_pkg.sv -----
package dwc_pkg;

    localparam int PIX_W   = 16;
    localparam int IDX_W   = 6;
    localparam int SLOT_W  = 3;
    localparam int SIZE_W  = 13;
    localparam int CNT_W   = 12;
    localparam int PROD_W  = 32;
    localparam int ROW_W   = 35;
    localparam int SUM_W   = 40;
    localparam int DATA_W  = 40;

    localparam logic REQ_WEIGHT = 1'b0;
    localparam logic REQ_PIXEL  = 1'b1;

    typedef enum logic [1:0] {
        REG_KERNEL  = 2'd0,
        REG_WIDTH   = 2'd1,
        REG_HEIGHT  = 2'd2,
        REG_CHANNEL = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic is_pixel;
        logic emit;
        logic row_done;
        logic plane_done;
        logic all_done;
    } flags_t;

    // Odd kernel side in 1..maxk
    function automatic logic [2:0] eff_kernel(logic [2:0] raw, logic [2:0] maxk);
        logic [2:0] kv;
        kv = raw;
        if (kv == 3'd0) kv = 3'd1;
        if (kv > maxk) kv = maxk;
        if (!kv[0]) kv = kv - 3'd1;
        return kv;
    endfunction

endpackage

// ----- rtl/depthwise_conv_kxk_stream.sv -----
// Depthwise KxK convolution over a raster pixel stream, valid mode. Load a
// plane's K*K weights as weight words (tuser 0), then send its pixels (tuser 1);
// one result word leaves per full window. The block takes one word per clock
// while its queue is not full; a four-entry queue parts the input side from a
// pipeline that reads the line banks in its first stage, updates the window and
// multiplies in the second, sums rows in the third, and adds the row sums into
// the output register. m_tready low holds the pipeline, and a full queue then
// drops s_tready. Any register write restarts the stream at column, row and
// plane zero; write registers only while idle.
module depthwise_conv_kxk_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 7,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input words
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // weight_index[5:0], weight_value[21:6], pixel_value[37:22]
    input  logic [0:0]   s_tuser,   // req_type
    // result words
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // conv_sum[39:0]
    output logic         m_tlast,   // row_done
    output logic [1:0]   m_tuser    // plane_done[0], all_done[1]
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int QW = $bits(dwc_pkg::flags_t) + dwc_pkg::SLOT_W + dwc_pkg::IDX_W
                        + dwc_pkg::PIX_W + AW;

    logic [2:0]                  kw_reg;
    logic [10:0]                 width_reg, height_reg, chan_reg;
    logic                        cfg_wr;
    dwc_pkg::reg_idx_t           cfg_idx;
    logic [2:0]                  k_eff;
    logic [dwc_pkg::SIZE_W-1:0]  w_eff, h_eff;
    logic [dwc_pkg::CNT_W-1:0]   c_eff;
    logic                        q_push, q_full, q_pop, q_valid;
    logic [QW-1:0]               q_in, q_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = dwc_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kw_reg     <= 3'd3;
            width_reg  <= 11'd64;
            height_reg <= 11'd64;
            chan_reg   <= 11'd1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                dwc_pkg::REG_KERNEL:  kw_reg     <= pwdata[2:0];
                dwc_pkg::REG_WIDTH:   width_reg  <= pwdata[10:0];
                dwc_pkg::REG_HEIGHT:  height_reg <= pwdata[10:0];
                dwc_pkg::REG_CHANNEL: chan_reg   <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            dwc_pkg::REG_KERNEL:  prdata = {29'd0, kw_reg};
            dwc_pkg::REG_WIDTH:   prdata = {21'd0, width_reg};
            dwc_pkg::REG_HEIGHT:  prdata = {21'd0, height_reg};
            dwc_pkg::REG_CHANNEL: prdata = {21'd0, chan_reg};
            default:              prdata = '0;
        endcase
    end

    // clamp the sizes to what the buffers hold
    always_comb begin
        k_eff = dwc_pkg::eff_kernel(kw_reg, 3'(MAX_KERNEL));
        if (width_reg == '0) w_eff = dwc_pkg::SIZE_W'(1);
        else if (dwc_pkg::SIZE_W'(width_reg) > dwc_pkg::SIZE_W'(MAX_WIDTH))
            w_eff = dwc_pkg::SIZE_W'(MAX_WIDTH);
        else w_eff = dwc_pkg::SIZE_W'(width_reg);
        if (height_reg == '0) h_eff = dwc_pkg::SIZE_W'(1);
        else if (dwc_pkg::SIZE_W'(height_reg) > dwc_pkg::SIZE_W'(MAX_HEIGHT))
            h_eff = dwc_pkg::SIZE_W'(MAX_HEIGHT);
        else h_eff = dwc_pkg::SIZE_W'(height_reg);
        c_eff = (chan_reg == '0) ? dwc_pkg::CNT_W'(1) : dwc_pkg::CNT_W'(chan_reg);
    end

    dwc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .QW(QW)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg_clear(cfg_wr),
        .k(k_eff), .w_eff(w_eff), .h_eff(h_eff), .c_eff(c_eff),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .q_full(q_full), .q_push(q_push), .q_data(q_in)
    );

    dwc_queue #(.QW(QW)) u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .push_data(q_in),
        .pop(q_pop), .full(q_full), .out_valid(q_valid), .out_data(q_out)
    );

    dwc_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL), .QW(QW)) u_back (
        .aclk(aclk), .aresetn(aresetn), .k(k_eff),
        .q_valid(q_valid), .q_data(q_out), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    // end of all implies end of plane implies end of row
    a_mark_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tlast)
        else $error("all_done without plane_done and row_done");

    a_plane_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("plane_done without row_done");

    // queue is empty right after reset
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

endmodule

// ----- rtl/dwc_front.sv -----
module dwc_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int QW         = 40
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_clear,
    input  logic [2:0]                  k,
    input  logic [dwc_pkg::SIZE_W-1:0]  w_eff,
    input  logic [dwc_pkg::SIZE_W-1:0]  h_eff,
    input  logic [dwc_pkg::CNT_W-1:0]   c_eff,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [dwc_pkg::DATA_W-1:0]  s_tdata,
    input  logic [0:0]                  s_tuser,
    input  logic                        q_full,
    output logic                        q_push,
    output logic [QW-1:0]               q_data
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT);

    logic [AW-1:0]                  col_reg, col_next;
    logic [HW-1:0]                  row_reg, row_next;
    logic [dwc_pkg::CNT_W-1:0]      plane_reg, plane_next;
    logic [dwc_pkg::SLOT_W-1:0]     base_reg, base_next;
    logic [dwc_pkg::SIZE_W-1:0]     col1, row1, kz;
    logic [dwc_pkg::CNT_W-1:0]      plane1;
    logic                           last_col, last_row, last_plane;
    logic                           is_pixel;
    dwc_pkg::flags_t                flags;
    logic [dwc_pkg::PIX_W-1:0]      value;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign is_pixel = (s_tuser[0] == dwc_pkg::REQ_PIXEL);

    assign col1       = dwc_pkg::SIZE_W'(col_reg) + dwc_pkg::SIZE_W'(1);
    assign row1       = dwc_pkg::SIZE_W'(row_reg) + dwc_pkg::SIZE_W'(1);
    assign plane1     = plane_reg + dwc_pkg::CNT_W'(1);
    assign kz         = dwc_pkg::SIZE_W'(k);
    assign last_col   = (col1 == w_eff);
    assign last_row   = (row1 == h_eff);
    assign last_plane = (plane1 >= c_eff);

    always_comb begin
        flags.is_pixel   = is_pixel;
        flags.emit       = (row1 >= kz) && (col1 >= kz) && (kz <= w_eff) && (kz <= h_eff);
        flags.row_done   = last_col;
        flags.plane_done = last_col && last_row;
        flags.all_done   = last_col && last_row && last_plane;
        value = is_pixel ? s_tdata[37:22] : s_tdata[21:6];
    end

    assign q_data = {flags, base_reg, s_tdata[5:0], value, col_reg};

    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        plane_next = plane_reg;
        base_next  = base_reg;
        if (cfg_clear) begin
            col_next   = '0;
            row_next   = '0;
            plane_next = '0;
            base_next  = '0;
        end else if (q_push && is_pixel) begin
            if (!last_col) begin
                col_next = col_reg + AW'(1);
            end else begin
                col_next = '0;
                if (!last_row) begin
                    row_next = row_reg + HW'(1);
                    if (k <= 3'd1 || ({1'b0, base_reg} + 4'd1) == ({1'b0, k} - 4'd1)) begin
                        base_next = '0;
                    end else begin
                        base_next = base_reg + dwc_pkg::SLOT_W'(1);
                    end
                end else begin
                    row_next   = '0;
                    base_next  = '0;
                    plane_next = last_plane ? '0 : plane1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            plane_reg <= '0;
            base_reg  <= '0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            plane_reg <= plane_next;
            base_reg  <= base_next;
        end
    end

endmodule

// ----- rtl/dwc_queue.sv -----
module dwc_queue #(
    parameter int QW = 40
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [QW-1:0] push_data,
    input  logic          pop,
    output logic          full,
    output logic          out_valid,
    output logic [QW-1:0] out_data
);
    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [QW-1:0] mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == (PW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !(pop && out_valid)) cnt_next = cnt_reg + (PW+1)'(1);
        else if (!push && pop && out_valid) cnt_next = cnt_reg - (PW+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + PW'(1);
            if (pop && out_valid) rd_reg <= rd_reg + PW'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/dwc_back.sv -----
module dwc_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 7,
    parameter int QW         = 40
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [2:0]                  k,
    input  logic                        q_valid,
    input  logic [QW-1:0]               q_data,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [dwc_pkg::DATA_W-1:0]  m_tdata,
    output logic                        m_tlast,
    output logic [1:0]                  m_tuser
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int NB = MAX_KERNEL - 1;
    localparam int NW = MAX_KERNEL * MAX_KERNEL;

    logic                               adv;
    // stage 1: entry from the queue
    logic                               s1_valid_reg;
    logic [QW-1:0]                      s1_reg;
    dwc_pkg::flags_t                    s1_flags;
    logic [dwc_pkg::SLOT_W-1:0]         s1_base;
    logic [dwc_pkg::IDX_W-1:0]          s1_widx;
    logic [dwc_pkg::PIX_W-1:0]          s1_value;
    logic [AW-1:0]                      s1_col;
    // stage 2: line data read, window update and products
    logic                               s2_valid_reg;
    dwc_pkg::flags_t                    s2_flags_reg;
    logic [dwc_pkg::SLOT_W-1:0]         s2_base_reg;
    logic signed [dwc_pkg::PIX_W-1:0]   s2_px_reg;
    logic signed [dwc_pkg::PIX_W-1:0]   line_rd_reg [NB];
    logic signed [dwc_pkg::PIX_W-1:0]   win_reg  [NW];
    logic signed [dwc_pkg::PIX_W-1:0]   win_next [NW];
    logic signed [dwc_pkg::PIX_W-1:0]   weight_reg [NW];
    logic signed [dwc_pkg::PIX_W-1:0]   wsel [NW];
    logic signed [dwc_pkg::PIX_W-1:0]   new_col [MAX_KERNEL];
    // stage 3: products
    logic                               s3_valid_reg;
    dwc_pkg::flags_t                    s3_flags_reg;
    logic signed [dwc_pkg::PROD_W-1:0]  prod_reg [NW];
    // stage 4: row sums
    logic                               s4_valid_reg;
    dwc_pkg::flags_t                    s4_flags_reg;
    logic signed [dwc_pkg::ROW_W-1:0]   rsum_reg [MAX_KERNEL];
    logic signed [dwc_pkg::ROW_W-1:0]   rsum_next [MAX_KERNEL];
    logic signed [dwc_pkg::SUM_W-1:0]   total;
    // output register
    logic                               out_valid_reg;
    logic [dwc_pkg::DATA_W-1:0]         out_data_reg;
    logic                               out_last_reg;
    logic [1:0]                         out_user_reg;

    assign adv   = !out_valid_reg || m_tready;
    assign q_pop = adv;

    assign {s1_flags, s1_base, s1_widx, s1_value, s1_col} = s1_reg;

    // line banks: one per stored row, read and written at the current column
    for (genvar b = 0; b < NB; b++) begin : g_bank
        logic [dwc_pkg::PIX_W-1:0] mem [MAX_WIDTH];
        always_ff @(posedge aclk) begin
            if (adv && s1_valid_reg && s1_flags.is_pixel) begin
                if (k > 3'd1 && s1_base == dwc_pkg::SLOT_W'(b)) mem[s1_col] <= s1_value;
                line_rd_reg[b] <= mem[s1_col];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s1_valid_reg && !s1_flags.is_pixel && int'(s1_widx) < NW) begin
            weight_reg[s1_widx] <= s1_value;
        end
    end

    always_comb begin
        logic [3:0] slot;
        for (int kr = 0; kr < MAX_KERNEL; kr++) begin
            slot = 4'({1'b0, s2_base_reg}) + 4'(kr);
            if (slot >= ({1'b0, k} - 4'd1)) slot = slot - ({1'b0, k} - 4'd1);
            new_col[kr] = s2_px_reg;
            if (kr + 1 < int'(k)) begin
                new_col[kr] = s2_px_reg;
                for (int b = 0; b < NB; b++) begin
                    if (slot == 4'(b)) new_col[kr] = line_rd_reg[b];
                end
            end
        end
        for (int kr = 0; kr < MAX_KERNEL; kr++) begin
            for (int kc = 0; kc < MAX_KERNEL; kc++) begin
                win_next[kr*MAX_KERNEL+kc] = win_reg[kr*MAX_KERNEL+kc];
                if (kr < int'(k)) begin
                    if (kc + 1 == int'(k)) begin
                        win_next[kr*MAX_KERNEL+kc] = new_col[kr];
                    end else if (kc + 1 < int'(k) && kc + 1 < MAX_KERNEL) begin
                        win_next[kr*MAX_KERNEL+kc] = win_reg[kr*MAX_KERNEL+kc+1];
                    end
                end
            end
        end
    end

    // weight for each window cell, by kernel side
    always_comb begin
        for (int kr = 0; kr < MAX_KERNEL; kr++) begin
            for (int kc = 0; kc < MAX_KERNEL; kc++) begin
                wsel[kr*MAX_KERNEL+kc] = '0;
                for (int kv = 1; kv <= MAX_KERNEL; kv += 2) begin
                    if (int'(k) == kv && kr < kv && kc < kv) begin
                        wsel[kr*MAX_KERNEL+kc] = weight_reg[kr*kv+kc];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s2_valid_reg && s2_flags_reg.is_pixel) begin
            for (int i = 0; i < NW; i++) begin
                win_reg[i]  <= win_next[i];
                prod_reg[i] <= wsel[i] * win_next[i];
            end
        end
    end

    always_comb begin
        for (int kr = 0; kr < MAX_KERNEL; kr++) begin
            rsum_next[kr] = '0;
            for (int kc = 0; kc < MAX_KERNEL; kc++) begin
                rsum_next[kr] = rsum_next[kr] + dwc_pkg::ROW_W'(prod_reg[kr*MAX_KERNEL+kc]);
            end
        end
        total = '0;
        for (int kr = 0; kr < MAX_KERNEL; kr++) begin
            total = total + dwc_pkg::SUM_W'(rsum_reg[kr]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg       <= q_data;
            s2_flags_reg <= s1_flags;
            s2_base_reg  <= s1_base;
            s2_px_reg    <= s1_value;
            s3_flags_reg <= s2_flags_reg;
            s4_flags_reg <= s3_flags_reg;
            for (int kr = 0; kr < MAX_KERNEL; kr++) rsum_reg[kr] <= rsum_next[kr];
            out_data_reg <= total;
            out_last_reg <= s4_flags_reg.row_done;
            out_user_reg <= {s4_flags_reg.all_done, s4_flags_reg.plane_done};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg && s2_flags_reg.is_pixel && s2_flags_reg.emit;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ----- bench/depthwise_conv_kxk_stream_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the streaming depthwise convolution.
// A short table of hand-checked words runs first. Then a series of configured
// phases runs: special register values and random small images.
// Each phase loads the kernel of every plane and then streams the pixels.
// An internal window/line-buffer model predicts every result word after the table.
// Both stream sides idle in random bursts.
module depthwise_conv_kxk_stream_tb;

    localparam int KMAX      = 7;
    localparam int WMAX      = 1024;
    localparam int HMAX      = 1024;
    localparam int CELLS     = KMAX * KMAX;
    localparam int QUIET_LEN = 4000;   // cycles with no handshake or register access before giving up
    localparam int SETTLE    = 12;     // idle cycles after the last result, to let the pipeline settle

    typedef struct packed {
        logic [39:0] sum;
        logic        row_done;
        logic        plane_done;
        logic        all_done;
    } conv_out_t;

    typedef struct {
        logic        req;
        logic [5:0]  idx;
        logic [15:0] wval;
        logic [15:0] pix;
        bit          known;
        conv_out_t   res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;      // weight_index[5:0], weight_value[21:6], pixel_value[37:22]
    logic [0:0]  s_tuser = '0;      // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;           // conv_sum[39:0]
    logic        m_tlast;           // row_done
    logic [1:0]  m_tuser;           // plane_done[0], all_done[1]

    depthwise_conv_kxk_stream i_dut (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------
    // Convolution model: line buffers, window, kernel, raster counters
    // ---------------------------------------------------------------
    logic signed [15:0] line_mem [0:(KMAX-1)*WMAX-1];
    logic signed [15:0] win_mem [0:CELLS-1];
    logic signed [15:0] kern_mem [0:CELLS-1];
    int unsigned col_pos, row_pos, plane_pos;
    int unsigned cfg_k = 3, cfg_w = 64, cfg_h = 64, cfg_c = 1;

    conv_out_t   sums_q [$];
    int          errors = 0;
    int          words_in = 0, words_out = 0, phases = 0;
    bit          quiet = 0;

    function automatic int unsigned kernel_side(int unsigned raw);
        int unsigned k;
        k = raw;
        if (k == 0) k = 1;
        if (k > KMAX) k = KMAX;
        if (k % 2 == 0) k = k - 1;
        return k;
    endfunction

    function automatic int unsigned fit_size(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Advance the model by one input word; return 1 when it yields a result.
    function automatic bit conv_step(input logic req, input logic [5:0] idx,
                                     input logic [15:0] wval, input logic [15:0] pix,
                                     output conv_out_t res);
        int unsigned k, w, h, c, col, row;
        longint acc;
        bit hit;
        res = '0;
        if (req == dwc_pkg::REQ_WEIGHT) begin
            if (idx < CELLS) kern_mem[idx] = wval;
            return 0;
        end
        k = kernel_side(cfg_k);
        w = fit_size(cfg_w, WMAX);
        h = fit_size(cfg_h, HMAX);
        c = (cfg_c == 0) ? 1 : cfg_c;
        col = (col_pos < w) ? col_pos : w - 1;
        row = row_pos;
        // shift the window left, pull the new column from the line banks
        for (int kr = 0; kr < k; kr++) begin
            for (int kc = 0; kc + 1 < k; kc++)
                win_mem[kr*KMAX + kc] = win_mem[kr*KMAX + kc + 1];
            if (kr + 1 < k)
                win_mem[kr*KMAX + k - 1] = line_mem[((row + kr) % (k - 1)) * WMAX + col];
            else
                win_mem[kr*KMAX + k - 1] = pix;
        end
        if (k > 1) line_mem[(row % (k - 1)) * WMAX + col] = pix;
        hit = (row + 1 >= k) && (col + 1 >= k) && (k <= w) && (k <= h);
        if (hit) begin
            acc = 0;
            for (int kr = 0; kr < k; kr++)
                for (int kc = 0; kc < k; kc++)
                    acc += longint'(int'(kern_mem[kr*k + kc]) * int'(win_mem[kr*KMAX + kc]));
            res.sum        = acc[39:0];
            res.row_done   = (col + 1 == w);
            res.plane_done = (col + 1 == w) && (row + 1 == h);
            res.all_done   = res.plane_done && (plane_pos + 1 >= c);
        end
        if (col + 1 < w) begin
            col_pos = col + 1;
        end else begin
            col_pos = 0;
            if (row + 1 < h) begin
                row_pos = row + 1;
            end else begin
                row_pos = 0;
                plane_pos = (plane_pos + 1 < c) ? plane_pos + 1 : 0;
            end
        end
        return hit;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    task automatic reg_write(input dwc_pkg::reg_idx_t r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (r)
            dwc_pkg::REG_KERNEL:  cfg_k = v[2:0];
            dwc_pkg::REG_WIDTH:   cfg_w = v[10:0];
            dwc_pkg::REG_HEIGHT:  cfg_h = v[10:0];
            default:              cfg_c = v[10:0];
        endcase
        col_pos = 0;
        row_pos = 0;
        plane_pos = 0;
    endtask

    // Send one word; queue the typed result when given, else the model's.
    task automatic send_word(input logic req, input logic [5:0] idx,
                             input logic [15:0] wval, input logic [15:0] pix,
                             input bit known, input conv_out_t typed);
        conv_out_t r;
        bit hit;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, pix, wval, idx};
        do @(posedge aclk); while (!s_tready);
        words_in++;
        hit = conv_step(req, idx, wval, pix, r);
        if (known) sums_q.push_back(typed);
        else if (hit) sums_q.push_back(r);
    endtask

    // Hold off until every result has left, then let the pipeline settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sums_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand16();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_noise();
        send_word(dwc_pkg::REQ_WEIGHT, 6'($urandom_range(CELLS, 63)), rand16(), rand16(),
                  0, '0);
    endtask

    // Configure, then for each plane load the kernel and stream its pixels.
    task automatic run_phase(input int unsigned k, input int unsigned w,
                             input int unsigned h, input int unsigned c);
        int unsigned ek, ew, eh, ec;
        drain();
        reg_write(dwc_pkg::REG_KERNEL,  k);
        reg_write(dwc_pkg::REG_WIDTH,   w);
        reg_write(dwc_pkg::REG_HEIGHT,  h);
        reg_write(dwc_pkg::REG_CHANNEL, c);
        phases++;
        ek = kernel_side(k);
        ew = fit_size(w, WMAX);
        eh = fit_size(h, HMAX);
        ec = (c == 0) ? 1 : c;
        for (int p = 0; p < ec; p++) begin
            for (int i = 0; i < ek * ek; i++) begin
                send_word(dwc_pkg::REQ_WEIGHT, 6'(i), rand16(), rand16(), 0, '0);
                if ($urandom_range(0, 15) == 0) send_noise();
            end
            for (int i = 0; i < ew * eh; i++) begin
                send_word(dwc_pkg::REQ_PIXEL, 6'($urandom), 16'($urandom), rand16(), 0, '0);
                if ($urandom_range(0, 40) == 0) send_noise();
            end
        end
        // occasionally run past the end of the stream into plane zero again
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2 * ew))
                send_word(dwc_pkg::REQ_PIXEL, 6'($urandom), 16'($urandom), rand16(), 0, '0);
    endtask

    // ---------------------------------------------------------------
    // Result side: random stall bursts, compare against oldest expectation
    // ---------------------------------------------------------------
    int stall_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                conv_out_t e;
                words_out++;
                if (sums_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word sum=%h", $time, m_tdata);
                end else begin
                    e = sums_q.pop_front();
                    if (m_tdata !== e.sum) begin
                        errors++;
                        $display("%0t: conv_sum expected %h actual %h", $time, e.sum, m_tdata);
                    end
                    if (m_tlast !== e.row_done) begin
                        errors++;
                        $display("%0t: row_done expected %b actual %b",
                                 $time, e.row_done, m_tlast);
                    end
                    if (m_tuser[0] !== e.plane_done) begin
                        errors++;
                        $display("%0t: plane_done expected %b actual %b",
                                 $time, e.plane_done, m_tuser[0]);
                    end
                    if (m_tuser[1] !== e.all_done) begin
                        errors++;
                        $display("%0t: all_done expected %b actual %b",
                                 $time, e.all_done, m_tuser[1]);
                    end
                end
            end
            // stall in bursts; keep ready high once the run goes quiet
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                stall_left <= $urandom_range(0, 15);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: give up when nothing moves for too long.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= QUIET_LEN) begin
            $display("%0t: timeout, %0d results outstanding", $time, sums_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    dir_row_t dir_tab [8];

    initial begin
        // 1x1 kernel over a 2x1 image, two planes: sums are plain products
        dir_tab = '{
            '{dwc_pkg::REQ_WEIGHT, 6'd0, 16'h7FFF, 16'h0000, 0, '0},
            '{dwc_pkg::REQ_PIXEL, 6'd0, 16'h0000, 16'h7FFF, 1,
              '{40'sd1073676289, 1'b0, 1'b0, 1'b0}},
            '{dwc_pkg::REQ_PIXEL, 6'd0, 16'h0000, 16'h8000, 1,
              '{-40'sd1073709056, 1'b1, 1'b1, 1'b0}},
            '{dwc_pkg::REQ_WEIGHT, 6'd0, 16'h8000, 16'h0000, 0, '0},
            '{dwc_pkg::REQ_WEIGHT, 6'd63, 16'h1234, 16'hFFFF, 0, '0},   // out-of-range index
            '{dwc_pkg::REQ_PIXEL, 6'd0, 16'h0000, 16'h8000, 1,
              '{40'sd1073741824, 1'b0, 1'b0, 1'b0}},
            '{dwc_pkg::REQ_PIXEL, 6'd0, 16'h0000, 16'h0001, 1,
              '{-40'sd32768, 1'b1, 1'b1, 1'b1}},
            '{dwc_pkg::REQ_PIXEL, 6'd0, 16'h0000, 16'h0000, 1,
              '{40'sd0, 1'b0, 1'b0, 1'b0}}
        };
        col_pos = 0;
        row_pos = 0;
        plane_pos = 0;
        for (int i = 0; i < CELLS; i++) kern_mem[i] = '0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        reg_write(dwc_pkg::REG_KERNEL,  1);
        reg_write(dwc_pkg::REG_WIDTH,   2);
        reg_write(dwc_pkg::REG_HEIGHT,  1);
        reg_write(dwc_pkg::REG_CHANNEL, 2);
        foreach (dir_tab[i])
            send_word(dir_tab[i].req, dir_tab[i].idx, dir_tab[i].wval, dir_tab[i].pix,
                      dir_tab[i].known, dir_tab[i].res);

        // register corner cases: odd/even/zero sides, zero sizes
        run_phase(0, 3, 2, 1);       // side 0 acts as 1
        run_phase(2, 4, 3, 1);       // even side drops to 1
        run_phase(7, 7, 7, 1);       // largest kernel, single window
        run_phase(4, 5, 4, 2);       // even side drops to 3
        run_phase(6, 6, 6, 1);       // even side drops to 5
        run_phase(3, 2, 2, 1);       // kernel larger than image: no results
        run_phase(1, 0, 3, 0);       // zero width and zero channel count
        run_phase(1, 2, 0, 1);       // zero height

        // random small images
        while (words_in < 1100) begin
            if (words_in > 900) quiet = 1;
            run_phase($urandom_range(0, 7), $urandom_range(1, 12),
                      $urandom_range(1, 8), $urandom_range(1, 3));
        end
        drain();

        $display("Sent %0d input words over %0d configurations, checked %0d results.",
                 words_in, phases, words_out);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dwc_pkg.sv
rtl/dwc_front.sv
rtl/dwc_queue.sv
rtl/dwc_back.sv
rtl/depthwise_conv_kxk_stream.sv
bench/depthwise_conv_kxk_stream_tb.sv
